@@ sv/dual_motor_pi_velocity_control_assert.svh @@
// Assertion macros used by the velocity controller sequencer.
`ifndef DUAL_MOTOR_PI_VELOCITY_CONTROL_ASSERT_SVH
`define DUAL_MOTOR_PI_VELOCITY_CONTROL_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DMPV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DMPV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/dmpv_pkg.sv @@
package dmpv_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_KP_RIGHT       = 3'd0;
  localparam logic [2:0] REG_KI_RIGHT       = 3'd1;
  localparam logic [2:0] REG_KP_LEFT        = 3'd2;
  localparam logic [2:0] REG_KI_LEFT        = 3'd3;
  localparam logic [2:0] REG_SAMPLE_PERIOD  = 3'd4;
  localparam logic [2:0] REG_VELOCITY_LIMIT = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Opcodes
  localparam logic [1:0] OP_RIGHT = 2'd0;
  localparam logic [1:0] OP_LEFT  = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [15:0] SAMPLE_PERIOD_RST  = 16'd655;
  localparam logic [14:0] VELOCITY_LIMIT_RST = 15'd1679;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_STEP,
    ST_INTEG,
    ST_MUL_I,
    ST_ITERM,
    ST_MUL_P,
    ST_CMD,
    ST_OUT
  } dmpv_state_t;

  typedef enum logic [1:0] {
    MUL_STEP,
    MUL_ITERM,
    MUL_PTERM
  } dmpv_mul_sel_t;

  typedef struct packed {
    logic          ld_in;
    logic          ld_err;
    logic          mul_en;
    dmpv_mul_sel_t mul_sel;
    logic          ld_integ;
    logic          ld_iterm;
    logic          ld_cmd;
    logic          ld_out;
  } dmpv_cmd_t;

  typedef struct packed {
    logic is_stop;
  } dmpv_sts_t;

endpackage

@@ sv/dmpv_ctrl.sv @@
module dmpv_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  dmpv_pkg::dmpv_sts_t sts,
  output dmpv_pkg::dmpv_cmd_t cmd
);
  import dmpv_pkg::*;

  dmpv_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_busy;
  logic        in_acc;

  assign out_busy = out_valid_r && out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_acc) state_nxt = ST_ERR;
      ST_ERR:      state_nxt = sts.is_stop ? ST_OUT : ST_MUL_STEP;
      ST_MUL_STEP: state_nxt = ST_INTEG;
      ST_INTEG:    state_nxt = ST_MUL_I;
      ST_MUL_I:    state_nxt = ST_ITERM;
      ST_ITERM:    state_nxt = ST_MUL_P;
      ST_MUL_P:    state_nxt = ST_CMD;
      ST_CMD:      state_nxt = ST_OUT;
      ST_OUT:      if (!out_busy) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_STEP;
    case (state_r)
      ST_IDLE:     cmd.ld_in = in_acc;
      ST_ERR:      cmd.ld_err = 1'b1;
      ST_MUL_STEP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_STEP;
      end
      ST_INTEG:    cmd.ld_integ = 1'b1;
      ST_MUL_I:    begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ITERM;
      end
      ST_ITERM:    cmd.ld_iterm = 1'b1;
      ST_MUL_P:    begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_PTERM;
      end
      ST_CMD:      cmd.ld_cmd = 1'b1;
      ST_OUT:      cmd.ld_out = !out_busy;
      default:     cmd = '0;
    endcase
  end

  assign out_valid_nxt = cmd.ld_out || out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`include "dual_motor_pi_velocity_control_assert.svh"

  `DMPV_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_acc, state_r == ST_ERR, "accept did not start work")
  `DMPV_ASSERT_NOW(a_valid_from_out, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_OUT, "result shown outside output step")
  `DMPV_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, state_r == ST_OUT && out_busy, state_r == ST_OUT, "finished result overwrote a held beat")
  `DMPV_ASSERT_NEXT(a_stop_skips, clk, rst_n, state_r == ST_ERR && sts.is_stop, state_r == ST_OUT, "stop ran the channel update")

endmodule

@@ sv/dmpv_datapath.sv @@
module dmpv_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic [1:0]          in_opcode,
  input  logic signed [15:0]  in_desired_velocity,
  input  logic signed [15:0]  in_measured_velocity,
  input  dmpv_pkg::dmpv_cmd_t cmd,
  output dmpv_pkg::dmpv_sts_t sts,
  output logic                out_right_write,
  output logic signed [9:0]   out_right_speed,
  output logic                out_left_write,
  output logic signed [9:0]   out_left_speed,
  output logic                out_bad_select
);
  import dmpv_pkg::*;

  localparam logic signed [37:0] ITERM_MAX = 38'sd819200;
  localparam logic signed [32:0] OUT_MAX   = 33'sd1638400;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647)       sat32 = 32'sh7fffffff;
    else if (v < -34'sd2147483648) sat32 = 32'sh80000000;
    else                           sat32 = v[31:0];
  endfunction

  // Configuration
  logic [23:0] kp_right_r, ki_right_r, kp_left_r, ki_left_r;
  logic [15:0] sample_period_r;
  logic [14:0] velocity_limit_r;

  // Channel state
  logic signed [31:0] integ_right_r, integ_left_r, last_right_r, last_left_r;

  // Item registers
  logic [1:0]         op_r;
  logic signed [15:0] des_r, meas_r;
  logic signed [16:0] err_r, err_nxt;
  logic signed [57:0] prod_r, prod_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [20:0] iterm_r, iterm_nxt;
  logic signed [31:0] cmd_r, cmd_nxt;

  logic is_left;
  logic is_stop;

  assign is_stop = op_r[1];
  assign is_left = (op_r == OP_LEFT);
  assign sts.is_stop = is_stop;

  // Clamp desired velocity and form the error
  logic signed [16:0] lim, des_c;
  always_comb begin
    lim = $signed({2'b00, velocity_limit_r});
    if ($signed({des_r[15], des_r}) > lim)       des_c = lim;
    else if ($signed({des_r[15], des_r}) < -lim) des_c = -lim;
    else                                         des_c = {des_r[15], des_r};
    err_nxt = des_c - {meas_r[15], meas_r};
  end

  // Shared multiplier operands
  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  always_comb begin
    case (cmd.mul_sel)
      MUL_STEP: begin
        mul_a = {{16{err_r[16]}}, err_r};
        mul_b = $signed({9'b0, sample_period_r});
      end
      MUL_ITERM: begin
        mul_a = {acc_r[31], acc_r};
        mul_b = $signed({1'b0, is_left ? ki_left_r : ki_right_r});
      end
      MUL_PTERM: begin
        mul_a = {{16{err_r[16]}}, err_r};
        mul_b = $signed({1'b0, is_left ? kp_left_r : kp_right_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // Integrator update
  logic signed [57:0] step_w;
  logic signed [31:0] integ_sel, last_sel;
  assign integ_sel = is_left ? integ_left_r : integ_right_r;
  assign last_sel  = is_left ? last_left_r : last_right_r;
  assign step_w    = prod_r >>> 8;
  assign acc_nxt   = sat32({{2{integ_sel[31]}}, integ_sel} + $signed(step_w[33:0]));

  // Integral term clamp
  logic signed [57:0] ish_w;
  always_comb begin
    ish_w = prod_r >>> 20;
    if ($signed(ish_w[37:0]) > ITERM_MAX)       iterm_nxt = ITERM_MAX[20:0];
    else if ($signed(ish_w[37:0]) < -ITERM_MAX) iterm_nxt = -ITERM_MAX[20:0];
    else                                        iterm_nxt = ish_w[20:0];
  end

  // Command sum
  logic signed [57:0] psh_w;
  assign psh_w   = prod_r >>> 12;
  assign cmd_nxt = sat32($signed(psh_w[33:0]) + {{13{iterm_r[20]}}, iterm_r}
                         + {{2{last_sel[31]}}, last_sel});

  // Output scaling: negate for left, clamp, truncate toward zero
  logic signed [32:0] cneg, ccl;
  logic signed [22:0] qsum;
  logic signed [22:0] spd_w;
  always_comb begin
    cneg = is_left ? -{cmd_r[31], cmd_r} : {cmd_r[31], cmd_r};
    if (cneg > OUT_MAX)       ccl = OUT_MAX;
    else if (cneg < -OUT_MAX) ccl = -OUT_MAX;
    else                      ccl = cneg;
    qsum  = ccl[22:0] + (ccl[32] ? 23'sd4095 : 23'sd0);
    spd_w = qsum >>> 12;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_right_r       <= '0;
      ki_right_r       <= '0;
      kp_left_r        <= '0;
      ki_left_r        <= '0;
      sample_period_r  <= SAMPLE_PERIOD_RST;
      velocity_limit_r <= VELOCITY_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP_RIGHT:       kp_right_r       <= cfg_data;
        REG_KI_RIGHT:       ki_right_r       <= cfg_data;
        REG_KP_LEFT:        kp_left_r        <= cfg_data;
        REG_KI_LEFT:        ki_left_r        <= cfg_data;
        REG_SAMPLE_PERIOD:  sample_period_r  <= cfg_data[15:0];
        REG_VELOCITY_LIMIT: velocity_limit_r <= cfg_data[14:0];
        default:            ;
      endcase
    end
  end

  // Channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_right_r <= '0;
      integ_left_r  <= '0;
      last_right_r  <= '0;
      last_left_r   <= '0;
    end else begin
      if (cmd.ld_integ) begin
        if (is_left) integ_left_r <= acc_nxt;
        else         integ_right_r <= acc_nxt;
      end
      if (cmd.ld_cmd) begin
        if (is_left) last_left_r <= cmd_nxt;
        else         last_right_r <= cmd_nxt;
      end
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      op_r   <= in_opcode;
      des_r  <= in_desired_velocity;
      meas_r <= in_measured_velocity;
    end
    if (cmd.ld_err)   err_r   <= err_nxt;
    if (cmd.mul_en)   prod_r  <= prod_nxt;
    if (cmd.ld_integ) acc_r   <= acc_nxt;
    if (cmd.ld_iterm) iterm_r <= iterm_nxt;
    if (cmd.ld_cmd)   cmd_r   <= cmd_nxt;
    if (cmd.ld_out) begin
      out_right_write <= is_stop || !is_left;
      out_left_write  <= is_stop || is_left;
      out_bad_select  <= is_stop;
      out_right_speed <= (is_stop || is_left) ? 10'sd0 : spd_w[9:0];
      out_left_speed  <= (is_stop || !is_left) ? 10'sd0 : spd_w[9:0];
    end
  end

endmodule

@@ sv/dual_motor_pi_velocity_control.sv @@
// A motor item steps through error, integrator, integral term, proportional term,
//   command and output states, using the single shared multiplier three times;
//   a stop item goes from error straight to output. Input is taken only when idle.
// A new input beat is taken while the previous result still waits on out_stall.
// Reset (rst_n low, synchronous): gains clear, sample_period 655, velocity_limit 1679,
//   integrators and last commands clear, no result pending.
module dual_motor_pi_velocity_control (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration write port
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic signed [15:0] in_desired_velocity,
  input  logic signed [15:0] in_measured_velocity,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_right_write,
  output logic signed [9:0]  out_right_speed,
  output logic               out_left_write,
  output logic signed [9:0]  out_left_speed,
  output logic               out_bad_select
);
  import dmpv_pkg::*;

  dmpv_cmd_t cmd;
  dmpv_sts_t sts;

  // Sequencer: walks error, integrator, integral term, proportional term, command
  // and output steps, and owns both handshakes.
  dmpv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: configuration, per-channel integrator and last command, one
  // shared multiplier, saturation and output scaling. The result beat is held
  // in its output registers until taken.
  dmpv_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_opcode            (in_opcode),
    .in_desired_velocity  (in_desired_velocity),
    .in_measured_velocity (in_measured_velocity),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_right_write      (out_right_write),
    .out_right_speed      (out_right_speed),
    .out_left_write       (out_left_write),
    .out_left_speed       (out_left_speed),
    .out_bad_select       (out_bad_select)
  );

endmodule
